// ===== hw/rtl/psa_pkg.sv =====
// Shared constants, codes and types of the palette slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package psa_pkg;

	localparam int SLOT_COUNT      = 256;
	localparam int FIRST_USER_SLOT = 16;
	localparam int USABLE_SLOTS    = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
	localparam int IDX_W           = (USABLE_SLOTS > 1) ? $clog2(USABLE_SLOTS) : 1;
	localparam int SLOT_W          = 8;
	localparam int COMP_W          = 8;
	localparam int COLOUR_W        = 3 * COMP_W;
	localparam int SCALED_W        = 10;

	// c * 1000 / 255 is computed as (c * SCALE_MUL) >> SCALE_SHIFT, exact for 8-bit c.
	localparam int SCALE_SHIFT = 26;
	localparam longint SCALE_MUL = 64'd263173000;
	localparam int SCALE_PROD_W = 37;

	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 4;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		STAT_NEW        = 4'd0,
		STAT_REUSED     = 4'd1,
		STAT_FULL       = 4'd2,
		STAT_UNINIT     = 4'd3,
		STAT_FREED      = 4'd4,
		STAT_IGNORED    = 4'd5,
		STAT_READ_HIT   = 4'd6,
		STAT_READ_EMPTY = 4'd7,
		STAT_CLEARED    = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE = 3'd0,
		FSM_SCAN = 3'd1,
		FSM_READ = 3'd2,
		FSM_FREE = 3'd3,
		FSM_WIPE = 3'd4,
		FSM_EMIT = 3'd5
	} fsm_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_W-1:0]     result_slot;
		logic [COLOUR_W-1:0]   read_colour;
		logic                  program_valid;
		logic [SLOT_W-1:0]     program_slot;
		logic                  program_scaled;
	} res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/psa_scale.sv =====
// Scales the three 8-bit colour components to the range 0..1000.
`timescale 1ns / 1ps
`default_nettype none
module psa_scale (
	input  wire logic [psa_pkg::COLOUR_W-1:0] colour,
	output logic      [psa_pkg::SCALED_W-1:0] scaled_red,
	output logic      [psa_pkg::SCALED_W-1:0] scaled_green,
	output logic      [psa_pkg::SCALED_W-1:0] scaled_blue
);
	import psa_pkg::*;

	logic [SCALE_PROD_W-1:0] prod_red;
	logic [SCALE_PROD_W-1:0] prod_green;
	logic [SCALE_PROD_W-1:0] prod_blue;

	assign prod_red   = SCALE_PROD_W'(colour[3*COMP_W-1:2*COMP_W]) * SCALE_PROD_W'(SCALE_MUL);
	assign prod_green = SCALE_PROD_W'(colour[2*COMP_W-1:COMP_W]) * SCALE_PROD_W'(SCALE_MUL);
	assign prod_blue  = SCALE_PROD_W'(colour[COMP_W-1:0]) * SCALE_PROD_W'(SCALE_MUL);

	assign scaled_red   = prod_red[SCALE_SHIFT+SCALED_W-1:SCALE_SHIFT];
	assign scaled_green = prod_green[SCALE_SHIFT+SCALED_W-1:SCALE_SHIFT];
	assign scaled_blue  = prod_blue[SCALE_SHIFT+SCALED_W-1:SCALE_SHIFT];

endmodule
`default_nettype wire

// ===== hw/rtl/palette_slot_allocator_core.sv =====
// Top level of the palette slot allocator: control, slot memory and output register.
// Allocate reads one memory entry per cycle for a matching colour and the lowest free user
// slot, clear writes every entry invalid. One item is in work at a time, and the next is
// accepted only after the result has been loaded into the output register.
// Reset clears the state, the initialized flag and the output valid; memory valid bits are
// ignored until the first clear, whose pass writes every entry.
`timescale 1ns / 1ps
`default_nettype none
module palette_slot_allocator_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// red [7:0], green [15:8], blue [23:16], slot [31:24]
	input  wire logic [psa_pkg::IN_DATA_W-1:0]    s_tdata,
	// op [1:0]
	input  wire logic [psa_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// result_slot [7:0], read_red [15:8], read_green [23:16], read_blue [31:24],
	// program_valid [32], program_slot [40:33], program_red [50:41],
	// program_green [60:51], program_blue [70:61], zero [71]
	output logic      [psa_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status [3:0]
	output logic      [psa_pkg::OUT_USER_W-1:0]   m_tuser
);
	import psa_pkg::*;

	localparam logic [SLOT_W:0] USABLE_LIM = (SLOT_W+1)'(USABLE_SLOTS);
	localparam logic [SLOT_W:0] FIRST_LIM  = (SLOT_W+1)'(FIRST_USER_SLOT);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(USABLE_SLOTS - 1);

	fsm_t                   state_q, state_d;
	logic                   init_q, init_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic                   found_q, found_d;
	logic [IDX_W-1:0]       fidx_q, fidx_d;
	res_t                   res_q, res_d;
	logic [COLOUR_W-1:0]    colour_q;
	logic [SLOT_W-1:0]      slot_q;

	logic [COLOUR_W:0]      mem [USABLE_SLOTS];
	logic [COLOUR_W:0]      rd_data_s1;
	logic [IDX_W-1:0]       rd_addr;
	logic                   mem_we;
	logic [IDX_W-1:0]       wr_addr;
	logic [COLOUR_W:0]      wr_data;
	logic                   rd_valid;
	logic [COLOUR_W-1:0]    rd_colour;

	logic                   m_tvalid_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;
	logic [OUT_USER_W-1:0]  m_tuser_q;
	logic                   out_free;
	logic                   out_load;

	op_t                    in_op;
	logic [SLOT_W-1:0]      in_slot;
	logic [COLOUR_W-1:0]    in_colour;
	logic                   q_slot_ok;
	logic                   scan_hit;
	logic                   scan_free;
	logic [SCALED_W-1:0]    scaled_red;
	logic [SCALED_W-1:0]    scaled_green;
	logic [SCALED_W-1:0]    scaled_blue;

	assign in_op        = op_t'(s_tuser);
	assign in_slot      = s_tdata[31:24];
	assign in_colour    = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
	assign rd_valid     = rd_data_s1[COLOUR_W];
	assign rd_colour    = rd_data_s1[COLOUR_W-1:0];
	assign q_slot_ok    = {1'b0, slot_q} < USABLE_LIM;
	assign scan_hit     = rd_valid && (rd_colour == colour_q);
	assign scan_free    = ((SLOT_W+1)'(idx_q) >= FIRST_LIM) && !rd_valid;
	assign out_free     = !m_tvalid_q || m_tready;

	psa_scale u_scale (
		.colour       (colour_q),
		.scaled_red   (scaled_red),
		.scaled_green (scaled_green),
		.scaled_blue  (scaled_blue)
	);

	always_comb begin
		state_d  = state_q;
		init_d   = init_q;
		idx_d    = idx_q;
		found_d  = found_q;
		fidx_d   = fidx_q;
		res_d    = res_q;
		s_tready = 1'b0;
		rd_addr  = idx_q + IDX_W'(1);
		mem_we   = 1'b0;
		wr_addr  = idx_q;
		wr_data  = '0;
		out_load = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				rd_addr  = (in_op == OP_READ || in_op == OP_FREE) ?
					in_slot[IDX_W-1:0] : '0;
				if (s_tvalid) begin
					idx_d   = '0;
					found_d = 1'b0;
					res_d   = '0;
					case (in_op)
						OP_ALLOC: begin
							if (!init_q) begin
								res_d.status = STAT_UNINIT;
								state_d      = FSM_EMIT;
							end else begin
								state_d = FSM_SCAN;
							end
						end
						OP_FREE: begin
							state_d = FSM_FREE;
						end
						OP_READ: begin
							state_d = FSM_READ;
						end
						OP_CLEAR: begin
							init_d  = 1'b1;
							state_d = FSM_WIPE;
						end
						default: begin
							state_d = FSM_IDLE;
						end
					endcase
				end
			end
			FSM_SCAN: begin
				if (scan_hit) begin
					res_d.status      = STAT_REUSED;
					res_d.result_slot = SLOT_W'(idx_q);
					state_d           = FSM_EMIT;
				end else begin
					if (scan_free && !found_q) begin
						found_d = 1'b1;
						fidx_d  = idx_q;
					end
					if (idx_q == LAST_IDX) begin
						if (found_q || scan_free) begin
							wr_addr              = found_q ? fidx_q : idx_q;
							wr_data              = {1'b1, colour_q};
							mem_we               = 1'b1;
							res_d.status         = STAT_NEW;
							res_d.result_slot    = SLOT_W'(wr_addr);
							res_d.program_valid  = 1'b1;
							res_d.program_slot   = SLOT_W'(wr_addr);
							res_d.program_scaled = 1'b1;
						end else begin
							res_d.status = STAT_FULL;
						end
						state_d = FSM_EMIT;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			FSM_READ: begin
				if (init_q && q_slot_ok && rd_valid) begin
					res_d.status      = STAT_READ_HIT;
					res_d.read_colour = rd_colour;
				end else begin
					res_d.status = STAT_READ_EMPTY;
				end
				state_d = FSM_EMIT;
			end
			FSM_FREE: begin
				if (!init_q || slot_q == '0 ||
						({1'b0, slot_q} >= FIRST_LIM && q_slot_ok && !rd_valid)) begin
					res_d.status = STAT_IGNORED;
				end else begin
					res_d.status        = STAT_FREED;
					res_d.program_valid = 1'b1;
					res_d.program_slot  = slot_q;
					if (q_slot_ok && rd_valid) begin
						mem_we  = 1'b1;
						wr_addr = slot_q[IDX_W-1:0];
						wr_data = {1'b0, rd_colour};
					end
				end
				state_d = FSM_EMIT;
			end
			FSM_WIPE: begin
				mem_we  = 1'b1;
				wr_addr = idx_q;
				wr_data = '0;
				if (idx_q == LAST_IDX) begin
					res_d.status = STAT_CLEARED;
					state_d      = FSM_EMIT;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			FSM_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			init_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		found_q <= found_d;
		fidx_q  <= fidx_d;
		res_q   <= res_d;
		if (s_tvalid && s_tready) begin
			colour_q <= in_colour;
			slot_q   <= in_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser_q <= res_q.status;
			m_tdata_q <= {1'b0,
				res_q.program_scaled ? scaled_blue : {SCALED_W{1'b0}},
				res_q.program_scaled ? scaled_green : {SCALED_W{1'b0}},
				res_q.program_scaled ? scaled_red : {SCALED_W{1'b0}},
				res_q.program_slot,
				res_q.program_valid,
				res_q.read_colour[COMP_W-1:0],
				res_q.read_colour[2*COMP_W-1:COMP_W],
				res_q.read_colour[3*COMP_W-1:2*COMP_W],
				res_q.result_slot};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_palette_slot_allocator_core.sv =====
// Self-checking testbench for the palette slot allocator core with its own result prediction.
`timescale 1ns / 1ps
module tb_palette_slot_allocator_core;
	import psa_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = USABLE_SLOTS + 16;
	localparam int IDLE_LIMIT   = 20 * (USABLE_SLOTS + 3);
	localparam int RANDOM_ITEMS = 1430;
	localparam int POOL_SIZE    = 16;

	typedef struct packed {
		status_t    status;
		logic [7:0] result_slot;
		logic [7:0] red_back;
		logic [7:0] green_back;
		logic [7:0] blue_back;
		logic       prog_valid;
		logic [7:0] prog_slot;
		logic [9:0] prog_red;
		logic [9:0] prog_green;
		logic [9:0] prog_blue;
	} palette_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [IN_USER_W-1:0]  s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	bit              slot_used [USABLE_SLOTS];
	logic [23:0]     slot_rgb [USABLE_SLOTS];
	bit              table_ready = 1'b0;
	palette_result_t pending_results [$];
	logic [23:0]     colour_pool [POOL_SIZE];

	int mismatch_count  = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int burst_left      = 0;
	int status_seen [9];
	int rx_phase        = 0;
	int rx_mode         = 0;

	always #(HALF_PERIOD) clk = ~clk;

	palette_slot_allocator_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic logic [9:0] scale_to_thousand(logic [7:0] c);
		return 10'(int'(c) * 1000 / 255);
	endfunction

	function automatic palette_result_t predict_palette_result(op_t op, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, logic [7:0] s);
		palette_result_t res;
		logic [23:0]     rgb;
		bit              done;
		res  = '0;
		rgb  = {r, g, b};
		done = 1'b0;
		case (op)
			OP_ALLOC: begin
				if (!table_ready) begin
					res.status = STAT_UNINIT;
				end else begin
					for (int i = 0; i < USABLE_SLOTS && !done; i++) begin
						if (slot_used[i] && slot_rgb[i] == rgb) begin
							res.status      = STAT_REUSED;
							res.result_slot = 8'(i);
							done            = 1'b1;
						end
					end
					for (int i = FIRST_USER_SLOT; i < USABLE_SLOTS && !done; i++) begin
						if (!slot_used[i]) begin
							slot_used[i]    = 1'b1;
							slot_rgb[i]     = rgb;
							res.status      = STAT_NEW;
							res.result_slot = 8'(i);
							res.prog_valid  = 1'b1;
							res.prog_slot   = 8'(i);
							res.prog_red    = scale_to_thousand(r);
							res.prog_green  = scale_to_thousand(g);
							res.prog_blue   = scale_to_thousand(b);
							done            = 1'b1;
						end
					end
					if (!done)
						res.status = STAT_FULL;
				end
			end
			OP_FREE: begin
				if (!table_ready || s == 0 ||
						(s >= FIRST_USER_SLOT && s < USABLE_SLOTS && !slot_used[s])) begin
					res.status = STAT_IGNORED;
				end else begin
					res.status     = STAT_FREED;
					res.prog_valid = 1'b1;
					res.prog_slot  = s;
					if (s < USABLE_SLOTS)
						slot_used[s] = 1'b0;
				end
			end
			OP_READ: begin
				if (s < USABLE_SLOTS && slot_used[s]) begin
					res.status     = STAT_READ_HIT;
					res.red_back   = slot_rgb[s][23:16];
					res.green_back = slot_rgb[s][15:8];
					res.blue_back  = slot_rgb[s][7:0];
				end else begin
					res.status = STAT_READ_EMPTY;
				end
			end
			default: begin
				foreach (slot_used[i])
					slot_used[i] = 1'b0;
				table_ready = 1'b1;
				res.status  = STAT_CLEARED;
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at result %0d, %s: got %0d, expected %0d", results_checked, what,
			got, want);
		mismatch_count++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic send_item(op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {s, b, g, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(predict_palette_result(op, r, g, b, s));
		items_sent++;
		burst_left--;
	endtask

	task automatic wait_results_done();
		s_tvalid  <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_before_clear();
		send_item(OP_ALLOC, 8'h12, 8'h34, 8'h56, 8'h00);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'd20);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'd0);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'd3);
		send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'd255);
		send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'd0);
	endtask

	task automatic test_basic_ops();
		send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
		send_item(OP_ALLOC, 8'h00, 8'h00, 8'h00, 8'h00);
		send_item(OP_ALLOC, 8'hff, 8'hff, 8'hff, 8'hff);
		send_item(OP_ALLOC, 8'hff, 8'hff, 8'hff, 8'h00);
		send_item(OP_ALLOC, 8'hff, 8'h00, 8'h80, 8'h00);
		send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'd17);
		send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'd18);
		send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'd19);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'd0);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'd5);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'd15);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'd255);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'd17);
		send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'd17);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'd17);
		send_item(OP_ALLOC, 8'h01, 8'h02, 8'h03, 8'h00);
		send_item(OP_ALLOC, 8'hff, 8'hff, 8'hff, 8'h00);
		send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
		send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'd16);
	endtask

	task automatic test_full_table();
		logic [23:0] first_rgb;
		logic [23:0] rgb;
		wait_results_done();
		send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
		for (int n = 0; n < USABLE_SLOTS - FIRST_USER_SLOT; n++) begin
			rgb = {8'($urandom), 8'($urandom), 8'(n)};
			if (n == 0)
				first_rgb = rgb;
			send_item(OP_ALLOC, rgb[23:16], rgb[15:8], rgb[7:0], 8'($urandom));
		end
		send_item(OP_ALLOC, 8'($urandom), 8'($urandom), 8'hff, 8'h00);
		send_item(OP_ALLOC, first_rgb[23:16], first_rgb[15:8], first_rgb[7:0], 8'h00);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00,
			8'($urandom_range(FIRST_USER_SLOT, USABLE_SLOTS - 1)));
		send_item(OP_ALLOC, 8'($urandom), 8'($urandom), 8'hfe, 8'h00);
		send_item(OP_ALLOC, 8'($urandom), 8'($urandom), 8'hfd, 8'h00);
		send_item(OP_FREE, 8'h00, 8'h00, 8'h00, 8'(USABLE_SLOTS - 1));
		send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'(USABLE_SLOTS - 1));
		send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_random_traffic();
		int          pick;
		op_t         op;
		logic [23:0] rgb;
		logic [7:0]  s;
		colour_pool[0] = 24'h000000;
		colour_pool[1] = 24'hffffff;
		for (int i = 2; i < POOL_SIZE; i++)
			colour_pool[i] = 24'($urandom);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				op = OP_ALLOC;
			else if (pick < 68)
				op = OP_FREE;
			else if (pick < 97)
				op = OP_READ;
			else
				op = OP_CLEAR;
			if ($urandom_range(0, 9) < 6)
				rgb = colour_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				rgb = 24'($urandom);
			if ($urandom_range(0, 9) < 7)
				s = 8'($urandom_range(FIRST_USER_SLOT, FIRST_USER_SLOT + 31));
			else
				s = 8'($urandom);
			if (n == RANDOM_ITEMS / 2)
				wait_results_done();
			send_item(op, rgb[23:16], rgb[15:8], rgb[7:0], s);
		end
	endtask

	always @(posedge clk) begin
		rx_phase++;
		if (rx_phase % 97 == 0)
			rx_mode = $urandom_range(0, 2);
		case (rx_mode)
			0: m_tready <= ($urandom_range(0, 2) == 0) ? 1'b1 : 1'b0;
			1: m_tready <= 1'b1;
			default: m_tready <= (rx_phase % 4 == 0) ? 1'b1 : 1'b0;
		endcase
	end

	always @(posedge clk) begin : check_results
		palette_result_t got;
		palette_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status      = status_t'(m_tuser);
			got.result_slot = m_tdata[7:0];
			got.red_back    = m_tdata[15:8];
			got.green_back  = m_tdata[23:16];
			got.blue_back   = m_tdata[31:24];
			got.prog_valid  = m_tdata[32];
			got.prog_slot   = m_tdata[40:33];
			got.prog_red    = m_tdata[50:41];
			got.prog_green  = m_tdata[60:51];
			got.prog_blue   = m_tdata[70:61];
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(m_tuser), 32'd0);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(got.status), 32'(want.status));
				check_field("result_slot", 32'(got.result_slot), 32'(want.result_slot));
				check_field("read_red", 32'(got.red_back), 32'(want.red_back));
				check_field("read_green", 32'(got.green_back), 32'(want.green_back));
				check_field("read_blue", 32'(got.blue_back), 32'(want.blue_back));
				check_field("program_valid", 32'(got.prog_valid), 32'(want.prog_valid));
				check_field("program_slot", 32'(got.prog_slot), 32'(want.prog_slot));
				check_field("program_red", 32'(got.prog_red), 32'(want.prog_red));
				check_field("program_green", 32'(got.prog_green), 32'(want.prog_green));
				check_field("program_blue", 32'(got.prog_blue), 32'(want.prog_blue));
				check_field("padding bit", 32'(m_tdata[71]), 32'd0);
				if (int'(want.status) < 9)
					status_seen[int'(want.status)]++;
			end
			results_checked++;
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_before_clear();
		test_basic_ops();
		test_full_table();
		test_random_traffic();
		wait_results_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items and checked %0d results with %0d mismatches.", items_sent,
			results_checked, mismatch_count);
		$display("Status counts: new %0d, reused %0d, full %0d, uninit %0d, freed %0d,",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		$display("  ignored %0d, read hit %0d, read empty %0d, cleared %0d.",
			status_seen[5], status_seen[6], status_seen[7], status_seen[8]);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
